>>> hw/rtl/pcpa_pkg.sv
// Shared constants for the per-CPU page allocator with list stealing.
// Holds parameter defaults, status codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package pcpa_pkg;

  // Parameter defaults
  localparam int NUM_CPUS_DEF   = 8;
  localparam int NUM_PAGES_DEF  = 32768;
  localparam int PAGE_BYTES_DEF = 4096;

  // Field widths fixed by the stream format
  localparam int ADDR_W   = 32;
  localparam int REQ_CPU_W = 3;
  localparam int STATUS_W = 2;
  localparam int TDATA_W  = 40;
  localparam int CFG_IDX_W = 1;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_LIMIT = 1'd1;

  // Configuration reset values
  localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] REGION_LIMIT_RST = 32'h8800_0000;

endpackage

`default_nettype wire

>>> hw/rtl/per_cpu_page_allocator_with_steal_top.sv
// Per-CPU LIFO free page lists with stealing on allocation.
// Heads and nonempty bits in flops, next links in a synchronous RAM.
// Depends on pcpa_pkg.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata, tuser (request)
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata, tuser (result)
//  cfg       in   cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// Each request goes through a find state (list search, head select and the
// next-link RAM read) and a commit state (head, nonempty and link write-back,
// result into the output register). The next request is taken during
// commit, so a new request can enter while the last one commits.
// Reset empties all lists at once; the link RAM needs no clearing pass.
// While a result waits on m_axis_tready, commit holds and input stalls in commit.
// PAGE_BYTES must be a power of two.
`default_nettype none

module per_cpu_page_allocator_with_steal_top
  import pcpa_pkg::*;
#(
  parameter int NUM_CPUS   = NUM_CPUS_DEF,
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // [2:0] requester_cpu, [34:3] page_address, [39:35] zero
  input  wire logic [TDATA_W-1:0]   s_axis_tdata,
  // [0] req_type
  input  wire logic                 s_axis_tuser,
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [31:0] granted_address, [34:32] served_cpu, [39:35] zero
  output logic [TDATA_W-1:0]        m_axis_tdata,
  // [1:0] status
  output logic [STATUS_W-1:0]       m_axis_tuser,
  // configuration writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ADDR_W-1:0]    cfg_data_i
);

  localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int SH     = $clog2(PAGE_BYTES);
  localparam int LINK_W = PAGE_W + 1;
  localparam int RED_W  = 7;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FIND   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]          state_q, state_d;

  logic [ADDR_W-1:0]   region_start_q, region_limit_q;

  logic                type_q;
  logic [CPU_W-1:0]    cpu_q;
  logic [ADDR_W-1:0]   addr_q;

  logic [PAGE_W-1:0]   head_q [NUM_CPUS];
  logic [NUM_CPUS-1:0] nonempty_q;

  logic                found_q, bad_q, ne_sel_q;
  logic [CPU_W-1:0]    sel_q;
  logic [PAGE_W-1:0]   head_sel_q, page_q;

  logic [LINK_W-1:0]   link_mem [NUM_PAGES];
  logic [LINK_W-1:0]   link_rd_q;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [REQ_CPU_W-1:0] out_cpu_q;

  logic                in_xfer, commit_go, commit;
  logic [CPU_W-1:0]    cpu_red_c;
  logic                found_c;
  logic [CPU_W-1:0]    sel_c, idx_c;
  logic                bad_c;
  logic [PAGE_W-1:0]   page_c;
  logic [ADDR_W-1:0]   base_c, diff_c, page_full_c, grant_c;
  logic                link_rd_en, link_wr_en;
  logic [LINK_W-1:0]   link_wr_data;

  // Handshakes
  assign commit_go     = !out_valid_q || m_axis_tready;
  assign commit        = (state_q == S_COMMIT) && commit_go;
  assign s_axis_tready = (state_q == S_IDLE) || commit;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Fold the requester onto the list range
  always_comb begin
    logic [RED_W-1:0] r;
    r = RED_W'(s_axis_tdata[REQ_CPU_W-1:0]);
    for (int j = 0; j < 7; j++) begin
      if (r >= RED_W'(NUM_CPUS)) r = r - RED_W'(NUM_CPUS);
    end
    cpu_red_c = r[CPU_W-1:0];
  end

  // Search the lists starting at the requester's own, lowest offset wins
  always_comb begin
    logic [CPU_W:0] s;
    found_c = 1'b0;
    sel_c   = '0;
    for (int k = NUM_CPUS - 1; k >= 0; k--) begin
      s = {1'b0, cpu_q} + (CPU_W + 1)'(k);
      if (s >= (CPU_W + 1)'(NUM_CPUS)) s = s - (CPU_W + 1)'(NUM_CPUS);
      if (nonempty_q[s[CPU_W-1:0]]) begin
        found_c = 1'b1;
        sel_c   = s[CPU_W-1:0];
      end
    end
  end

  // Check a freed address and turn it into a page number
  assign base_c      = region_start_q & ~ADDR_W'(PAGE_BYTES - 1);
  assign diff_c      = addr_q - base_c;
  assign page_full_c = diff_c >> SH;
  assign page_c      = page_full_c[PAGE_W-1:0];
  assign bad_c       = (|addr_q[SH-1:0]) || (addr_q < region_start_q) ||
                       (addr_q >= region_limit_q) ||
                       (page_full_c >= ADDR_W'(NUM_PAGES));

  // Frees work on the home list, allocations on the found one
  assign idx_c = (type_q == REQ_FREE) ? cpu_q : sel_c;

  // Link RAM ports
  assign link_rd_en   = (state_q == S_FIND) && (type_q == REQ_ALLOC) && found_c;
  assign link_wr_en   = commit && (type_q == REQ_FREE) && !bad_q;
  assign link_wr_data = ne_sel_q ? {1'b1, head_sel_q} : '0;

  always_ff @(posedge clk_i) begin
    if (link_wr_en) link_mem[page_q] <= link_wr_data;
    if (link_rd_en) link_rd_q <= link_mem[head_q[idx_c]];
  end

  assign grant_c = base_c + (ADDR_W'(head_sel_q) << SH);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_xfer) state_d = S_FIND;
      S_FIND:   state_d = S_COMMIT;
      S_COMMIT: if (commit) state_d = in_xfer ? S_FIND : S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= REGION_START_RST;
      region_limit_q <= REGION_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_REGION_START: region_start_q <= cfg_data_i;
        CFG_REGION_LIMIT: region_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      type_q <= s_axis_tuser;
      cpu_q  <= cpu_red_c;
      addr_q <= s_axis_tdata[REQ_CPU_W +: ADDR_W];
    end
  end

  // Hold the find results for commit
  always_ff @(posedge clk_i) begin
    if (state_q == S_FIND) begin
      found_q    <= found_c;
      bad_q      <= bad_c;
      page_q     <= page_c;
      sel_q      <= idx_c;
      head_sel_q <= head_q[idx_c];
      ne_sel_q   <= nonempty_q[idx_c];
    end
  end

  // List heads: push on a good free, pop on a served allocation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CPUS; i++) head_q[i] <= '0;
      nonempty_q <= '0;
    end else if (commit) begin
      if (type_q == REQ_FREE) begin
        if (!bad_q) begin
          head_q[sel_q]     <= page_q;
          nonempty_q[sel_q] <= 1'b1;
        end
      end else if (found_q) begin
        if (link_rd_q[LINK_W-1]) begin
          head_q[sel_q] <= link_rd_q[PAGE_W-1:0];
        end else begin
          head_q[sel_q]     <= '0;
          nonempty_q[sel_q] <= 1'b0;
        end
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (commit) begin
      priority if (type_q == REQ_FREE && bad_q) begin
        out_status_q <= ST_BAD;
        out_addr_q   <= '0;
        out_cpu_q    <= '0;
      end else if (type_q == REQ_FREE) begin
        out_status_q <= ST_DONE;
        out_addr_q   <= '0;
        out_cpu_q    <= REQ_CPU_W'(sel_q);
      end else if (found_q) begin
        out_status_q <= ST_DONE;
        out_addr_q   <= grant_c;
        out_cpu_q    <= REQ_CPU_W'(sel_q);
      end else begin
        out_status_q <= ST_EMPTY;
        out_addr_q   <= '0;
        out_cpu_q    <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(TDATA_W - ADDR_W - REQ_CPU_W)'(0), out_cpu_q, out_addr_q};
  assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire
